>>> rtl/core/raster_binary_float_op_defines.svh
// Assertion macros shared by the raster float operator RTL.
// No dependencies; included by the top level.
`ifndef RASTER_BINARY_FLOAT_OP_DEFINES_SVH
`define RASTER_BINARY_FLOAT_OP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define RBF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/rbf_pkg.sv
// Package for the raster float operator: payload types, opcodes, constants.
// No dependencies.
package rbf_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rbf_op_t;

  localparam logic [0:0] REG_NODATA_ENABLE = 1'b0;
  localparam logic [0:0] REG_NODATA_BITS   = 1'b1;
  localparam int CFG_IDX_W = 1;

  localparam logic [31:0] FALLBACK_BITS  = 32'hC61C3C00;
  localparam logic [31:0] NODATA_RESET   = 32'hC61C3C00;
  localparam logic [31:0] CANON_NAN      = 32'h7FC00000;
  localparam int          QUEUE_DEPTH    = 2;
  localparam int          DIV_STAGES     = 8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] a_bits;
    logic [31:0] b_bits;
    logic        b_valid;
  } rbf_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        fallback;
  } rbf_out_t;

  // Classified item passed from front to back.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] a_bits;
    logic [31:0] b_bits;
    logic        bypass;
    logic [31:0] bypass_bits;
  } rbf_job_t;

  function automatic logic f32_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f32_eq(input logic [31:0] x, input logic [31:0] y);
    if (f32_is_nan(x) || f32_is_nan(y)) return 1'b0;
    if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) return 1'b1;
    return x == y;
  endfunction

endpackage

>>> rtl/core/rbf_front.sv
// Front part: resolves the B substitute and the NoData / small divisor cases.
// Depends on rbf_pkg.
module rbf_front import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rbf_in_t     in_data,
  input  logic        nd_en,
  input  logic [31:0] nd_bits,
  output logic        job_valid,
  input  logic        job_ready,
  output rbf_job_t    job
);
  logic        job_valid_r;
  rbf_job_t    job_r;
  logic [31:0] b_eff;
  logic        nd_hit, small_div;
  rbf_job_t    job_nxt;

  always_comb begin
    b_eff = in_data.b_valid ? in_data.b_bits : (nd_en ? nd_bits : 32'd0);
    nd_hit = nd_en && (f32_eq(in_data.a_bits, nd_bits) || f32_eq(b_eff, nd_bits));
    // |B| <= 2^-23 means biased exponent below 104, or exactly 2^-23.
    small_div = (in_data.opcode == OP_DIV) &&
                (f32_is_nan(b_eff) || (b_eff[30:23] < 8'd104) ||
                 (b_eff[30:0] == {8'd104, 23'd0}));
    job_nxt.opcode      = in_data.opcode;
    job_nxt.a_bits      = in_data.a_bits;
    job_nxt.b_bits      = b_eff;
    job_nxt.bypass      = nd_hit || small_div;
    job_nxt.bypass_bits = nd_hit ? nd_bits : (nd_en ? nd_bits : FALLBACK_BITS);
  end

  assign in_ready  = !job_valid_r || job_ready;
  assign job_valid = job_valid_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (in_ready) begin
      job_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      job_r <= job_nxt;
    end
  end
endmodule

>>> rtl/core/rbf_queue.sv
// Short FIFO between the front and back parts.
// Depends on rbf_pkg.
module rbf_queue import rbf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  rbf_job_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output rbf_job_t rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  rbf_job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

>>> rtl/core/rbf_back.sv
// Back part: pipelined binary32 add/sub/mul/div with round-to-nearest-even.
// Depends on rbf_pkg.
module rbf_back import rbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  output logic     job_ready,
  input  rbf_job_t job,
  output logic     out_valid,
  input  logic     out_ready,
  output rbf_out_t out_data
);
  // Stage layout: 0 unpack/add/mul, 1..DIV_STAGES iterations share the slot,
  // then a pass stage, then normalize/round into the output register.
  // Every stage advances as one when the output can move.
  localparam int NS = DIV_STAGES + 3;
  // Restoring division: each stage yields DIV_BPS quotient bits, and the
  // whole quotient must fit the 50-bit significand field.
  localparam int DIV_BPS  = 50 / DIV_STAGES;
  localparam int DIV_BITS = DIV_BPS * DIV_STAGES;

  typedef struct packed {
    logic        v;
    logic [1:0]  op;
    logic        bypass;
    logic [31:0] bypass_bits;
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic signed [11:0] exp;   // exponent of value = mant * 2^(exp)
    logic [49:0] mant;         // magnitude, or quotient bits so far
    logic [26:0] rem;          // divide remainder
    logic [23:0] div_d;        // divisor significand
  } st_t;

  st_t stg_r [NS];
  st_t last_nxt;
  logic adv;
  assign adv = !stg_r[NS-1].v || out_ready;
  assign job_ready = adv;
  assign out_valid = stg_r[NS-1].v;
  assign out_data.result_bits = stg_r[NS-1].special_bits;
  assign out_data.fallback    = stg_r[NS-1].bypass;

  // Unpack operands.
  logic        sa, sb, sb_eff;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic signed [11:0] xa, xb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  st_t         s0;
  logic [24:0] big_m, sml_m;
  logic signed [11:0] big_x;
  logic        big_s, sml_s;
  logic [11:0] shamt;
  logic [49:0] big_w, sml_w;
  logic        sticky;
  logic [49:0] sum;
  logic        res_s;

  function automatic logic [4:0] lz24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 23; i >= 0; i--) begin
      if (m[i]) return 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [23:0] norm24(input logic [23:0] m);
    return m << lz24(m);
  endfunction

  function automatic st_t div_step(input st_t s);
    st_t r;
    logic [26:0] rm;
    r  = s;
    rm = s.rem;
    for (int i = 0; i < DIV_BPS; i++) begin
      r.mant = {r.mant[48:0], rm >= {3'd0, s.div_d}};
      if (rm >= {3'd0, s.div_d}) rm = rm - {3'd0, s.div_d};
      rm = {rm[25:0], 1'b0};
    end
    r.rem = rm;
    return r;
  endfunction

  // Normalize and round to binary32.
  function automatic logic [31:0] round32(input logic sg, input logic signed [11:0] ex,
                                          input logic [49:0] m, input logic stk_in);
    logic [5:0]  msb;
    logic signed [12:0] e_unb;
    logic signed [12:0] sh;
    logic [49:0] kept;
    logic        g, stk, lsb;
    logic [24:0] q;
    logic [7:0]  be;
    logic [75:0] wide;
    msb = 6'd0;
    for (int i = 0; i < 50; i++) if (m[i]) msb = 6'(i);
    if (m == 0 && !stk_in) return {sg, 31'd0};
    // Value = m * 2^ex; target exponent of leading bit.
    e_unb = 13'(ex) + 13'(msb);
    // Shift so the kept significand has 24 bits, or fewer for subnormals.
    if (e_unb < -13'sd126) sh = 13'(msb) - 13'sd23 + (-13'sd126 - e_unb);
    else sh = 13'(msb) - 13'sd23;
    wide = {m, 26'd0};
    if (sh >= 0) begin
      wide = wide >> sh;
    end else begin
      wide = wide << (-sh);
    end
    kept = wide[75:26];
    g    = wide[25];
    // Sticky covers every bit of m below the guard bit.
    if (sh <= 0) stk = stk_in;
    else if (sh > 13'sd50) stk = stk_in || (m != 0);
    else stk = stk_in || ((m & ~(50'h3FFFFFFFFFFFF << (sh - 13'sd1))) != 0);
    lsb = kept[0];
    q = 25'(kept[23:0]) + 25'(g && (stk || lsb));
    if (e_unb < -13'sd126) begin
      be = q[23] ? 8'd1 : 8'd0;
      return {sg, be, q[22:0]};
    end
    if (q[24]) begin
      e_unb = e_unb + 13'sd1;
      q = q >> 1;
    end
    if (e_unb > 13'sd127) return {sg, 8'hFF, 23'd0};
    be = 8'(e_unb + 13'sd127);
    return {sg, be, q[22:0]};
  endfunction

  always_comb begin
    sa = job.a_bits[31]; ea = job.a_bits[30:23];
    sb = job.b_bits[31]; eb = job.b_bits[30:23];
    ma = {ea != 0, job.a_bits[22:0]};
    mb = {eb != 0, job.b_bits[22:0]};
    xa = (ea == 0) ? -12'sd149 : $signed({4'd0, ea}) - 12'sd150;
    xb = (eb == 0) ? -12'sd149 : $signed({4'd0, eb}) - 12'sd150;
    a_nan = f32_is_nan(job.a_bits); b_nan = f32_is_nan(job.b_bits);
    a_inf = (ea == 8'hFF) && !a_nan; b_inf = (eb == 8'hFF) && !b_nan;
    a_zero = job.a_bits[30:0] == 0; b_zero = job.b_bits[30:0] == 0;
    sb_eff = sb ^ (job.opcode == OP_SUB);

    s0 = '0;
    s0.v = job_valid;
    s0.op = job.opcode;
    s0.bypass = job.bypass;
    s0.bypass_bits = job.bypass_bits;
    big_m = '0; sml_m = '0; big_x = '0; big_s = 1'b0; sml_s = 1'b0;
    shamt = '0; big_w = '0; sml_w = '0; sticky = 1'b0; sum = '0; res_s = 1'b0;

    unique case (rbf_op_t'(job.opcode))
      OP_ADD, OP_SUB: begin
        if (a_nan || b_nan || (a_inf && b_inf && (sa != sb_eff))) begin
          s0.special = 1'b1; s0.special_bits = CANON_NAN;
        end else if (a_inf) begin
          s0.special = 1'b1; s0.special_bits = {sa, 8'hFF, 23'd0};
        end else if (b_inf) begin
          s0.special = 1'b1; s0.special_bits = {sb_eff, 8'hFF, 23'd0};
        end else if (a_zero && b_zero) begin
          s0.special = 1'b1; s0.special_bits = {sa & sb_eff, 31'd0};
        end else begin
          if ((xa > xb) || ((xa == xb) && (ma >= mb))) begin
            big_m = {1'b0, ma}; big_x = xa; big_s = sa;
            sml_m = {1'b0, mb}; sml_s = sb_eff; shamt = 12'(xa - xb);
          end else begin
            big_m = {1'b0, mb}; big_x = xb; big_s = sb_eff;
            sml_m = {1'b0, ma}; sml_s = sa; shamt = 12'(xb - xa);
          end
          // Align in a 50-bit window with 24 guard bits below.
          big_w = {1'b0, big_m, 24'd0};
          if (shamt > 12'd48) begin
            sml_w = 50'd1;
          end else begin
            sml_w = {1'b0, sml_m, 24'd0} >> shamt;
            sticky = ({1'b0, sml_m, 24'd0} & ~(50'h3FFFFFFFFFFFF << shamt)) != 0;
            sml_w = sml_w | 50'(sticky);
          end
          if (big_s == sml_s) begin
            sum = big_w + sml_w; res_s = big_s;
          end else begin
            sum = big_w - sml_w; res_s = big_s;
          end
          s0.sign = (sum == 0) ? 1'b0 : res_s;
          s0.exp  = big_x - 12'sd24;
          s0.mant = sum;
        end
      end
      OP_MUL: begin
        s0.sign = sa ^ sb;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
          s0.special = 1'b1; s0.special_bits = CANON_NAN;
        end else if (a_inf || b_inf) begin
          s0.special = 1'b1; s0.special_bits = {sa ^ sb, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
          s0.special = 1'b1; s0.special_bits = {sa ^ sb, 31'd0};
        end else begin
          s0.mant = {2'd0, 48'(ma) * 48'(mb)};
          s0.exp  = xa + xb;
        end
      end
      OP_DIV: begin
        s0.sign = sa ^ sb;
        if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
          s0.special = 1'b1; s0.special_bits = CANON_NAN;
        end else if (a_inf || b_zero) begin
          s0.special = 1'b1; s0.special_bits = {sa ^ sb, 8'hFF, 23'd0};
        end else if (a_zero || b_inf) begin
          s0.special = 1'b1; s0.special_bits = {sa ^ sb, 31'd0};
        end else begin
          // Pre-normalize both significands to bit 23.
          s0.rem   = 27'(norm24(ma));
          s0.div_d = norm24(mb);
          // The first quotient bit has weight 2^0, the last 2^-(DIV_BITS-1).
          s0.exp   = (xa - 12'(lz24(ma))) - (xb - 12'(lz24(mb))) - 12'(DIV_BITS - 1);
          s0.mant  = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    last_nxt = stg_r[NS-2];
    if (stg_r[NS-2].bypass)
      last_nxt.special_bits = stg_r[NS-2].bypass_bits;
    else if (!stg_r[NS-2].special)
      last_nxt.special_bits = round32(stg_r[NS-2].sign, stg_r[NS-2].exp,
        stg_r[NS-2].mant,
        (stg_r[NS-2].op == OP_DIV) && (stg_r[NS-2].rem != 0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) stg_r[i].v <= 1'b0;
    end else if (adv) begin
      stg_r[0] <= s0;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        if (stg_r[i-1].op == OP_DIV && !stg_r[i-1].special && !stg_r[i-1].bypass)
          stg_r[i] <= div_step(stg_r[i-1]);
        else
          stg_r[i] <= stg_r[i-1];
      end
      stg_r[NS-2] <= stg_r[NS-3];
      stg_r[NS-1] <= last_nxt;
    end
  end
endmodule

>>> rtl/core/raster_binary_float_op.sv
// Raster pixel-wise binary32 operator with NoData handling (top level).
// Depends on rbf_pkg, rbf_front, rbf_queue, rbf_back and the defines header.
// Usage:
//   in_* carries one pixel pair per beat (opcode, A, B, B present flag).
//   out_* returns one result beat per input beat, in order, with a fallback
//   flag when the result is NoData or the divide fallback value.
//   cfg_we/cfg_idx/cfg_wdata write nodata_enable (0) and nodata_bits (1);
//   write them only while no beat is in flight.
// Throughput: one beat per cycle while out_ready is high. From the accepting
//   edge to out_valid a beat passes the front register, the queue and the
//   back-end stages, whose depth is set by the iterative divider stages,
//   which all operations pass through.
// Reset (rst_n low, synchronous) empties every stage and restores
//   nodata_enable = 0, nodata_bits = -9999.0.
// When out_ready is low the back end holds, the queue fills, and in_ready
//   drops once the front register is also full; no beat is lost.
`include "raster_binary_float_op_defines.svh"
module raster_binary_float_op import rbf_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbf_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rbf_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata
);
  logic        nd_en_r;
  logic [31:0] nd_bits_r;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  rbf_job_t    fj, bj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_en_r   <= 1'b0;
      nd_bits_r <= NODATA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NODATA_ENABLE: nd_en_r   <= cfg_wdata[0];
        REG_NODATA_BITS:   nd_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rbf_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .nd_en(nd_en_r), .nd_bits(nd_bits_r),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  rbf_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  rbf_back u_back (
    .clk, .rst_n,
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid, .out_ready, .out_data
  );

  `RBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RBF_ASSERT_IMPL(a_fb_nodata, clk, rst_n,
    out_valid && out_data.fallback && nd_en_r, out_data.result_bits == nd_bits_r)
  `RBF_ASSERT_IMPL(a_fb_default, clk, rst_n,
    out_valid && out_data.fallback && !nd_en_r, out_data.result_bits == FALLBACK_BITS)
endmodule

>>> dv/rbf_scoreboard.sv
// Scoreboard class for the raster float operator: result prediction and checking.
// Depends on rbf_pkg for the payload types and opcodes.
`timescale 1ns / 100ps
import rbf_pkg::*;

class rbf_scoreboard;
  logic        nd_on;
  logic [31:0] nd_bits;
  rbf_out_t    pending_results[$];
  int          errors;
  int          n_in;
  int          n_out;
  int          n_fallback;

  function new();
    nd_on = 1'b0;
    nd_bits = NODATA_RESET;
    errors = 0;
    n_in = 0;
    n_out = 0;
    n_fallback = 0;
  endfunction

  static function logic is_nan32(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  // Floating-point equality: signed zeros match, NaN matches nothing.
  static function logic same_value(logic [31:0] x, logic [31:0] y);
    if (is_nan32(x) || is_nan32(y)) return 1'b0;
    if (x[30:0] == 0 && y[30:0] == 0) return 1'b1;
    return x == y;
  endfunction

  static function real widen(logic [31:0] x);
    logic [63:0] d;
    real r;
    if (x[30:23] == 8'hFF) begin
      d = {x[31], 11'h7FF, x[22:0], 29'd0};
      return $bitstoreal(d);
    end
    if (x[30:23] == 0) begin
      r = $itor(x[22:0]) * (2.0 ** (-149));
      return x[31] ? -r : r;
    end
    d = {x[31], 11'(int'(x[30:23]) - 127 + 1023), x[22:0], 29'd0};
    return $bitstoreal(d);
  endfunction

  // Round a double to binary32, nearest-even, with subnormals.
  static function logic [31:0] narrow(real r);
    logic [63:0] d, sig, kept, rem, half;
    int e, fe, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {d[63], 8'hFF, 23'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) return {d[63], 31'd0};
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    if (e >= -126) begin
      fe = e + 127;
      if (kept == (64'd1 << 24)) begin
        kept = kept >> 1;
        fe++;
      end
      if (fe >= 255) return {d[63], 8'hFF, 23'd0};
      return {d[63], 8'(fe), kept[22:0]};
    end
    // A carry out of a subnormal lands on the smallest normal on its own.
    return {d[63], kept[30:0]};
  endfunction

  function rbf_out_t pixel_result(rbf_in_t px);
    rbf_out_t res;
    logic [31:0] b;
    real x, y, z;
    b = px.b_valid ? px.b_bits : (nd_on ? nd_bits : 32'd0);
    res.fallback = 1'b0;
    if (nd_on && (same_value(px.a_bits, nd_bits) || same_value(b, nd_bits))) begin
      res.result_bits = nd_bits;
      res.fallback = 1'b1;
      return res;
    end
    // 0x34000000 is 2^-23; magnitude bit patterns order like the values.
    if (rbf_op_t'(px.opcode) == OP_DIV && (is_nan32(b) || b[30:0] <= 31'h34000000)) begin
      res.result_bits = nd_on ? nd_bits : FALLBACK_BITS;
      res.fallback = 1'b1;
      return res;
    end
    x = widen(px.a_bits);
    y = widen(b);
    case (rbf_op_t'(px.opcode))
      OP_ADD: z = x + y;
      OP_SUB: z = x - y;
      OP_MUL: z = x * y;
      default: z = x / y;
    endcase
    res.result_bits = narrow(z);
    if (is_nan32(res.result_bits)) res.result_bits = CANON_NAN;
    return res;
  endfunction

  function void note_input(rbf_in_t px);
    pending_results.push_back(pixel_result(px));
    n_in++;
  endfunction

  function void check_result(rbf_out_t got);
    rbf_out_t want;
    n_out++;
    if (got.fallback) n_fallback++;
    if (pending_results.size() == 0) begin
      $display("%0t ERROR: unexpected result beat %h/%b", $time,
               got.result_bits, got.fallback);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.result_bits !== want.result_bits) begin
      $display("%0t ERROR: result_bits expected %h actual %h", $time,
               want.result_bits, got.result_bits);
      errors++;
    end
    if (got.fallback !== want.fallback) begin
      $display("%0t ERROR: fallback expected %b actual %b", $time,
               want.fallback, got.fallback);
      errors++;
    end
  endfunction
endclass

>>> dv/tb_top.sv
// Top-level testbench for raster_binary_float_op: clock, reset, stimulus and checks.
// Depends on rbf_pkg and the scoreboard class in rbf_scoreboard.sv.
`timescale 1ns / 100ps
module tb_top;
  import rbf_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  rbf_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  rbf_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_wdata;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;
  rbf_scoreboard pixel_sb;

  raster_binary_float_op dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready is rerolled every edge, results checked at the falling edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) pixel_sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired with %0d results pending", $time,
               pixel_sb.pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NODATA_ENABLE) pixel_sb.nd_on = val[0];
    else pixel_sb.nd_bits = val;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pixel_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Called just after a rising edge; returns after the taking edge and any idle gap.
  task automatic send_pixel(rbf_in_t px);
    in_valid <= 1'b1;
    in_data <= px;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pixel_sb.note_input(px);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] specials[16] = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000,
      32'h7FC00000, 32'hFFA00001, 32'h3F800000, 32'h34000000, 32'hB4000000,
      32'h34000001, 32'h33FFFFFF, 32'h00000001, 32'h807FFFFF, 32'h00800000,
      32'h7F7FFFFF, 32'hFF7FFFFF};
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1: return specials[$urandom_range(15)];
      2: return pixel_sb.nd_bits;
      3: return {pixel_sb.nd_bits[31] ^ 1'b1, pixel_sb.nd_bits[30:0]};
      4, 5: return $urandom();
      default: begin
        // Moderate exponents so that operations interact and round.
        v = $urandom();
        v[30:23] = 8'($urandom_range(100, 154));
        return v;
      end
    endcase
  endfunction

  function automatic rbf_in_t random_pixel();
    rbf_in_t px;
    px.opcode = 2'($urandom_range(3));
    px.a_bits = pick_operand();
    px.b_bits = pick_operand();
    px.b_valid = ($urandom_range(9) != 0);
    return px;
  endfunction

  initial begin
    logic [31:0] nd_values[8] = '{NODATA_RESET, 32'h0, 32'h80000000, 32'h7FC00001,
      32'hFFFFFFFF, 32'h3F800000, 32'h7F800000, 32'h00000001};
    logic [31:0] edge_ops[6] = '{32'h0, 32'hFFFFFFFF, 32'h7F7FFFFF, 32'h80000001,
      32'h34000000, 32'h3F800000};
    rbf_in_t px;
    pixel_sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every opcode over field extremes, reset configuration.
    for (int i = 0; i < 24; i++) begin
      px.opcode = 2'(i % 4);
      px.a_bits = edge_ops[i % 6];
      px.b_bits = edge_ops[(i / 4) % 6];
      px.b_valid = (i % 5 != 4);
      send_pixel(px);
    end
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_NODATA_ENABLE, (ph == 0 || ph == 4) ? 32'hFFFFFFFE : 32'h1);
      write_reg(REG_NODATA_BITS, (ph == 5) ? $urandom() : nd_values[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int i = 0; i < 100; i++) begin
        send_pixel(random_pixel());
        if (i == 50) begin
          // Let the pipeline run dry mid-phase.
          in_valid <= 1'b0;
          do @(posedge clk); while (pixel_sb.pending_results.size() != 0);
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    $display("Sent %0d pixel beats over 8 NoData settings; %0d results checked, %0d fallback.",
             pixel_sb.n_in, pixel_sb.n_out, pixel_sb.n_fallback);
    if (pixel_sb.errors == 0 && pixel_sb.pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

>>> raster_binary_float_op.f
+incdir+rtl/core
rtl/core/rbf_pkg.sv
rtl/core/rbf_front.sv
rtl/core/rbf_queue.sv
rtl/core/rbf_back.sv
rtl/core/raster_binary_float_op.sv
dv/rbf_scoreboard.sv
dv/tb_top.sv
